### sv/csiu_pkg.sv
// shared types, codes and helpers of the stack instruction unit
package csiu_pkg;

   localparam int BYTE_W      = 8;
   localparam int ACT_W       = 3;
   localparam int STACK_DEPTH = 1 << BYTE_W;

   // action codes
   localparam logic [ACT_W-1:0] ACT_TSX = 3'd0;
   localparam logic [ACT_W-1:0] ACT_TXS = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PHA = 3'd2;
   localparam logic [ACT_W-1:0] ACT_PHP = 3'd3;
   localparam logic [ACT_W-1:0] ACT_PLA = 3'd4;
   localparam logic [ACT_W-1:0] ACT_PLP = 3'd5;

   // flag layout
   localparam int               FLAG_N_BIT  = 7;
   localparam int               FLAG_Z_BIT  = 1;
   localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hDF;
   localparam logic [BYTE_W-1:0] SIGN_LIMIT  = 8'd128;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_out;
   } csiu_cmd_type;

   typedef struct packed {
      logic pull;
   } csiu_sts_type;

   function automatic logic [BYTE_W-1:0] set_nz(input logic [BYTE_W-1:0] flags,
                                                 input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] res;
      res             = flags;
      res[FLAG_N_BIT] = (value >= SIGN_LIMIT);
      res[FLAG_Z_BIT] = (value == '0);
      return res;
   endfunction

endpackage

### sv/csiu_req_if.sv
// request channel of the stack instruction unit
interface csiu_req_if import csiu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] acc_in;
   logic [BYTE_W-1:0] index_x_in;
   logic [BYTE_W-1:0] status_in;

   modport source(output valid, action, acc_in, index_x_in, status_in, input ready);
   modport sink(input valid, action, acc_in, index_x_in, status_in, output ready);
endinterface

### sv/csiu_rsp_if.sv
// response channel of the stack instruction unit
interface csiu_rsp_if import csiu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] acc_out;
   logic [BYTE_W-1:0] index_x_out;
   logic [BYTE_W-1:0] status_out;
   logic [BYTE_W-1:0] sp_out;

   modport source(output valid, acc_out, index_x_out, status_out, sp_out, input ready);
   modport sink(input valid, acc_out, index_x_out, status_out, sp_out, output ready);
endinterface

### sv/csiu_ram.sv
// generic single-write, single-read ram with registered read
module csiu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/csiu_dp.sv
// datapath: captured item, stack pointer, stack page and result register
module csiu_dp import csiu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  csiu_cmd_type      cmd,
   output csiu_sts_type      sts,
   input  logic [ACT_W-1:0]  action,
   input  logic [BYTE_W-1:0] acc_in,
   input  logic [BYTE_W-1:0] index_x_in,
   input  logic [BYTE_W-1:0] status_in,
   output logic [BYTE_W-1:0] acc_out,
   output logic [BYTE_W-1:0] index_x_out,
   output logic [BYTE_W-1:0] status_out,
   output logic [BYTE_W-1:0] sp_out
);

   logic [ACT_W-1:0]  op_ff;
   logic [BYTE_W-1:0] acc_ff, x_ff, p_ff;
   logic [BYTE_W-1:0] sp_ff, sp_in;
   logic [BYTE_W-1:0] acc_out_ff, x_out_ff, p_out_ff, sp_out_ff;
   logic [BYTE_W-1:0] res_acc, res_x, res_p;
   logic [BYTE_W-1:0] rd_data, wr_data;
   logic              is_push, is_pull;

   assign is_push  = (op_ff == ACT_PHA) || (op_ff == ACT_PHP);
   assign is_pull  = (op_ff == ACT_PLA) || (op_ff == ACT_PLP);
   assign sts.pull = is_pull;
   assign wr_data  = (op_ff == ACT_PHA) ? acc_ff : p_ff;

   // item capture, bit 5 dropped on the way in
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= action;
         acc_ff <= acc_in;
         x_ff   <= index_x_in;
         p_ff   <= status_in & STATUS_MASK;
      end
   end

   always_comb begin
      sp_in = sp_ff;
      if (cmd.exec) begin
         if (op_ff == ACT_TXS) begin
            sp_in = x_ff;
         end else if (is_push) begin
            sp_in = sp_ff - BYTE_W'(1);
         end else if (is_pull) begin
            sp_in = sp_ff + BYTE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // push writes at the old pointer, pull reads at the new one
   csiu_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (cmd.exec && is_push),
      .wr_addr(sp_ff),
      .wr_data(wr_data),
      .rd_en  (cmd.exec && is_pull),
      .rd_addr(sp_in),
      .rd_data(rd_data)
   );

   // result formed once the pointer is updated and any pulled byte is back
   always_comb begin
      res_acc = acc_ff;
      res_x   = x_ff;
      res_p   = p_ff;
      unique case (op_ff)
         ACT_TSX: begin
            res_x = sp_ff;
            res_p = set_nz(p_ff, sp_ff);
         end
         ACT_PLA: begin
            res_acc = rd_data;
            res_p   = set_nz(p_ff, rd_data);
         end
         ACT_PLP: begin
            res_p = rd_data & STATUS_MASK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         acc_out_ff <= res_acc;
         x_out_ff   <= res_x;
         p_out_ff   <= res_p & STATUS_MASK;
         sp_out_ff  <= sp_ff;
      end
   end

   assign acc_out     = acc_out_ff;
   assign index_x_out = x_out_ff;
   assign status_out  = p_out_ff;
   assign sp_out      = sp_out_ff;

   a_push_decrements: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_push |=> sp_ff == $past(sp_ff) - BYTE_W'(1))
      else $error("push did not decrement the stack pointer");

   a_pull_increments: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_pull |=> sp_ff == $past(sp_ff) + BYTE_W'(1))
      else $error("pull did not increment the stack pointer");

endmodule

### sv/csiu_ctrl.sv
// controller: sequences capture, execute, read and result load of one item
module csiu_ctrl import csiu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  csiu_sts_type sts,
   output csiu_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.pull ? ST_READ : ST_LOAD;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // wait for the result register to free up
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted item did not move to execute");

   a_read_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(state_ff) == ST_EXEC)
      else $error("read state entered without execute");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !out_valid_ff || rsp_ready)
      else $error("result overwritten before it was taken");

endmodule

### sv/cpu_stack_instruction_unit_top.sv
// Stack instruction unit: runs TSX, TXS, PHA, PHP, PLA and PLP against an
// 8-bit stack pointer (reset to zero) and a 256-byte stack page held in a
// ram with registered read. One item is in flight at a time. An item holds
// the block through the capture, execute and load steps; PLA and PLP also
// pass a read step between execute and load, for the ram read. The result
// register is written at the end of the load step, and no new item is
// taken before then. The result sits in an output register, so the next
// item is taken in the cycle after the result is loaded, even if the
// consumer has not yet taken it. If the previous result is still
// waiting in that register, the load cycle repeats until the consumer
// takes it. A pulled stack byte that was never pushed since reset reads as
// an unknown value.
module cpu_stack_instruction_unit_top import csiu_pkg::*; (
   input logic        clock,
   input logic        reset,
   csiu_req_if.sink   req_if,
   csiu_rsp_if.source rsp_if
);

   csiu_cmd_type cmd;
   csiu_sts_type sts;

   csiu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   csiu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .action     (req_if.action),
      .acc_in     (req_if.acc_in),
      .index_x_in (req_if.index_x_in),
      .status_in  (req_if.status_in),
      .acc_out    (rsp_if.acc_out),
      .index_x_out(rsp_if.index_x_out),
      .status_out (rsp_if.status_out),
      .sp_out     (rsp_if.sp_out)
   );

endmodule
